// File: design/dba_pkg.sv
`default_nettype none

package dba_pkg;

	// Default disk size in blocks.
	localparam int NUM_BLOCKS_DEF = 64;

	// Fixed field widths.
	localparam int ID_W   = 8;
	localparam int LEN_W  = 7;
	localparam int MODE_W = 2;

	// Longest file that a single create may ask for.
	localparam logic [LEN_W-1:0] MAX_LEN = 7'd64;

	// Request kinds.
	localparam logic OP_CREATE = 1'b0;
	localparam logic OP_DELETE = 1'b1;

	// Allocation strategies; the two remaining codes both select indexed allocation.
	localparam logic [MODE_W-1:0] MODE_CONTIG  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_LINKED  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_INDEXED = 2'd2;
	localparam logic [MODE_W-1:0] MODE_SPARE   = 2'd3;

	// Answer codes.
	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NO_SPACE  = 3'd1,
		ST_EXISTS    = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_ZERO_LEN  = 3'd4
	} status_t;

endpackage

`default_nettype wire

// File: design/disk_block_allocator.sv
// Delete: one sweep over the owner table, then one answer beat.
// Create: one sweep over the owner table, then, if space is found, a second sweep from the
//   first chosen block, one block per cycle while the output register can take each beat.
// One request at a time: the owner RAM's single read port sets the pace of both sweeps.
// After reset the owner RAM is cleared one entry per cycle, every entry in turn, with in_ready low.
`default_nettype none

module disk_block_allocator import dba_pkg::*; #(
	parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
	localparam int AW = $clog2(NUM_BLOCKS),
	localparam int CW = $clog2(NUM_BLOCKS + 1)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,

	input  wire logic              cfg_wr_en,
	input  wire logic [MODE_W-1:0] cfg_wr_data,

	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              op,
	input  wire logic [ID_W-1:0]   file_id,
	input  wire logic [LEN_W-1:0]  file_length,

	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic      [2:0]        status,
	output logic      [AW-1:0]     block_number,
	output logic      [CW-1:0]     link_block,
	output logic                   last
);

	// The user must change the allocation mode only while the block is idle (the block does
	// not enforce it), so the engine may read it directly throughout a request.
	logic [MODE_W-1:0] alloc_mode_q;

	// Output register: it parts the engine from the consumer, so the engine keeps
	// sweeping whenever the register is empty or is being emptied in this cycle.
	logic          out_valid_q;
	status_t       status_q;
	logic [AW-1:0] block_q;
	logic [CW-1:0] link_q;
	logic          last_q;

	logic          slot_free;
	logic          em_valid;
	status_t       em_status;
	logic [AW-1:0] em_block;
	logic [CW-1:0] em_link;
	logic          em_last;

	logic            mem_rd_en;
	logic [AW-1:0]   mem_rd_addr;
	logic [ID_W-1:0] mem_rd_data;
	logic            mem_wr_en;
	logic [AW-1:0]   mem_wr_addr;
	logic [ID_W-1:0] mem_wr_data;

	assign slot_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alloc_mode_q <= MODE_CONTIG;
		end else if (cfg_wr_en) begin
			alloc_mode_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (em_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Payload needs no reset; it is only looked at while out_valid is high.
	always_ff @(posedge clk) begin
		if (em_valid) begin
			status_q <= em_status;
			block_q  <= em_block;
			link_q   <= em_link;
			last_q   <= em_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign block_number = block_q;
	assign link_block   = link_q;
	assign last         = last_q;

	dba_owner_ram #(
		.NUM_BLOCKS (NUM_BLOCKS)
	) u_owner_ram (
		.clk     (clk),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data)
	);

	dba_engine #(
		.NUM_BLOCKS (NUM_BLOCKS)
	) u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.alloc_mode  (alloc_mode_q),
		.req_valid   (in_valid),
		.req_ready   (in_ready),
		.req_op      (op),
		.req_id      (file_id),
		.req_len     (file_length),
		.slot_free   (slot_free),
		.em_valid    (em_valid),
		.em_status   (em_status),
		.em_block    (em_block),
		.em_link     (em_link),
		.em_last     (em_last),
		.mem_rd_en   (mem_rd_en),
		.mem_rd_addr (mem_rd_addr),
		.mem_rd_data (mem_rd_data),
		.mem_wr_en   (mem_wr_en),
		.mem_wr_addr (mem_wr_addr),
		.mem_wr_data (mem_wr_data)
	);

endmodule

`default_nettype wire

// File: design/dba_owner_ram.sv
`default_nettype none

module dba_owner_ram import dba_pkg::*; #(
	parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
	localparam int AW = $clog2(NUM_BLOCKS)
) (
	input  wire logic            clk,
	input  wire logic            rd_en,
	input  wire logic [AW-1:0]   rd_addr,
	output logic      [ID_W-1:0] rd_data,
	input  wire logic            wr_en,
	input  wire logic [AW-1:0]   wr_addr,
	input  wire logic [ID_W-1:0] wr_data
);

	// One owner id per block; 0 marks a free block.
	logic [ID_W-1:0] mem_q [NUM_BLOCKS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read data holds while the read enable is low.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// File: design/dba_engine.sv
`default_nettype none

module dba_engine import dba_pkg::*; #(
	parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
	localparam int AW = $clog2(NUM_BLOCKS),
	localparam int CW = $clog2(NUM_BLOCKS + 1)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [MODE_W-1:0] alloc_mode,
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire logic              req_op,
	input  wire logic [ID_W-1:0]   req_id,
	input  wire logic [LEN_W-1:0]  req_len,
	input  wire logic              slot_free,
	output logic                   em_valid,
	output status_t                em_status,
	output logic      [AW-1:0]     em_block,
	output logic      [CW-1:0]     em_link,
	output logic                   em_last,
	output logic                   mem_rd_en,
	output logic      [AW-1:0]     mem_rd_addr,
	input  wire logic [ID_W-1:0]   mem_rd_data,
	output logic                   mem_wr_en,
	output logic      [AW-1:0]     mem_wr_addr,
	output logic      [ID_W-1:0]   mem_wr_data
);

	localparam int XW = (CW > LEN_W) ? CW : LEN_W;
	localparam logic [CW-1:0] LINK_NONE = CW'(NUM_BLOCKS);

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_SCAN1, S_SCAN2, S_FINAL, S_RESP
	} state_t;

	state_t           state_q;
	logic [CW-1:0]    rd_addr_q;
	logic             vld_s1;
	logic [AW-1:0]    addr_s1;
	logic [CW-1:0]    cnt_q;
	logic             found_q;
	logic             present_q;
	logic [AW-1:0]    start_q;
	logic             pend_v_q;
	logic [AW-1:0]    pend_blk_q;
	logic             op_q;
	logic [ID_W-1:0]  id_q;
	logic [LEN_W-1:0] len_q;
	status_t          resp_q;

	logic          contig, indexed, is_free, last_addr, stall, advance, issue_done;
	logic          hit, present_nxt, found_nxt;
	logic [CW-1:0] cnt_inc, cnt_nxt;
	logic [XW-1:0] len_ext;
	logic [AW-1:0] start_nxt;

	always_comb begin
		contig      = (alloc_mode == MODE_CONTIG);
		indexed     = (alloc_mode != MODE_CONTIG) && (alloc_mode != MODE_LINKED);
		is_free     = (mem_rd_data == '0);
		last_addr   = (addr_s1 == AW'(NUM_BLOCKS - 1));
		issue_done  = (rd_addr_q == CW'(NUM_BLOCKS));
		len_ext     = XW'(len_q);
		cnt_inc     = cnt_q + CW'(1);
		present_nxt = present_q || (mem_rd_data == id_q);

		// Contiguous mode counts the current free run, the others all free blocks so far.
		if (is_free) begin
			cnt_nxt = cnt_inc;
		end else if (contig) begin
			cnt_nxt = '0;
		end else begin
			cnt_nxt = cnt_q;
		end
		hit       = !found_q && is_free && (XW'(cnt_inc) == len_ext);
		found_nxt = found_q || hit;

		start_nxt = start_q;
		if (contig) begin
			if (hit) begin
				start_nxt = AW'(XW'(addr_s1) + XW'(1) - len_ext);
			end
		end else if (is_free && (cnt_q == '0)) begin
			start_nxt = addr_s1;
		end

		stall   = (state_q == S_SCAN2) && vld_s1 && is_free && pend_v_q && !slot_free;
		advance = !stall;

		req_ready   = (state_q == S_IDLE);
		mem_rd_en   = advance && !issue_done && ((state_q == S_SCAN1) || (state_q == S_SCAN2));
		mem_rd_addr = rd_addr_q[AW-1:0];

		mem_wr_en   = 1'b0;
		mem_wr_addr = addr_s1;
		mem_wr_data = '0;
		em_valid    = 1'b0;
		em_status   = ST_OK;
		em_block    = '0;
		em_link     = LINK_NONE;
		em_last     = 1'b0;

		unique case (state_q)
			S_CLEAR: begin
				mem_wr_en   = 1'b1;
				mem_wr_addr = rd_addr_q[AW-1:0];
			end
			S_SCAN1: begin
				mem_wr_en = vld_s1 && (op_q == OP_DELETE) && (mem_rd_data == id_q);
			end
			S_SCAN2: begin
				mem_wr_en   = vld_s1 && is_free && !stall;
				mem_wr_data = id_q;
				// Picking a new block releases the one picked before it.
				if (vld_s1 && is_free && pend_v_q) begin
					em_valid = slot_free;
					em_block = pend_blk_q;
					em_link  = indexed ? CW'(start_q) : CW'(addr_s1);
				end
			end
			S_FINAL: begin
				em_valid = slot_free;
				em_block = pend_blk_q;
				em_link  = indexed ? CW'(start_q) : LINK_NONE;
				em_last  = 1'b1;
			end
			S_RESP: begin
				em_valid  = slot_free;
				em_status = resp_q;
				em_last   = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			rd_addr_q <= '0;
			vld_s1    <= 1'b0;
			cnt_q     <= '0;
			found_q   <= 1'b0;
			present_q <= 1'b0;
			pend_v_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					rd_addr_q <= rd_addr_q + CW'(1);
					if (rd_addr_q == CW'(NUM_BLOCKS - 1)) begin
						rd_addr_q <= '0;
						state_q   <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						op_q      <= req_op;
						id_q      <= req_id;
						len_q     <= req_len;
						rd_addr_q <= '0;
						vld_s1    <= 1'b0;
						cnt_q     <= '0;
						found_q   <= 1'b0;
						present_q <= 1'b0;
						pend_v_q  <= 1'b0;
						state_q   <= S_SCAN1;
					end
				end
				S_SCAN1: begin
					vld_s1  <= mem_rd_en;
					addr_s1 <= rd_addr_q[AW-1:0];
					if (mem_rd_en) begin
						rd_addr_q <= rd_addr_q + CW'(1);
					end
					if (vld_s1) begin
						cnt_q     <= cnt_nxt;
						present_q <= present_nxt;
						found_q   <= found_nxt;
						start_q   <= start_nxt;
						if (last_addr) begin
							vld_s1   <= 1'b0;
							cnt_q    <= '0;
							pend_v_q <= 1'b0;
							state_q  <= S_RESP;
							if (op_q == OP_DELETE) begin
								resp_q <= ((id_q == '0) || !present_nxt) ? ST_NOT_FOUND
									: ST_OK;
							end else if ((id_q == '0) || present_nxt) begin
								resp_q <= ST_EXISTS;
							end else if (len_q == '0) begin
								resp_q <= ST_ZERO_LEN;
							end else if ((len_q > MAX_LEN) || (len_ext > XW'(NUM_BLOCKS))
								|| !found_nxt) begin
								resp_q <= ST_NO_SPACE;
							end else begin
								rd_addr_q <= CW'(start_nxt);
								state_q   <= S_SCAN2;
							end
						end
					end
				end
				S_SCAN2: begin
					if (advance) begin
						vld_s1  <= mem_rd_en;
						addr_s1 <= rd_addr_q[AW-1:0];
						if (mem_rd_en) begin
							rd_addr_q <= rd_addr_q + CW'(1);
						end
						if (vld_s1 && is_free) begin
							pend_v_q   <= 1'b1;
							pend_blk_q <= addr_s1;
							cnt_q      <= cnt_inc;
							if (XW'(cnt_inc) == len_ext) begin
								vld_s1  <= 1'b0;
								state_q <= S_FINAL;
							end
						end
					end
				end
				S_FINAL, S_RESP: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_emit_needs_slot: assert property (@(posedge clk) disable iff (!arst_n)
		em_valid |-> slot_free)
		else $error("result beat issued while the output register is occupied");

	a_no_write_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !mem_wr_en)
		else $error("owner table written while no request is in progress");

	a_last_ends_request: assert property (@(posedge clk) disable iff (!arst_n)
		(em_valid && em_last) |=> (state_q == S_IDLE))
		else $error("request still active after its final beat");

	a_stall_holds_read: assert property (@(posedge clk) disable iff (!arst_n)
		(stall && (state_q == S_SCAN2)) |=> (vld_s1 && $stable(addr_s1)))
		else $error("scan stage moved on while stalled");

	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(NUM_BLOCKS))
		else $error("block counter exceeds the disk size");

endmodule

`default_nettype wire

// File: test/disk_block_allocator_test.sv
`default_nettype none

// Self-checking bench for the disk block allocator.
//
// A queue of jobs is filled before the run starts. Most jobs are create or delete requests;
// the others either change the allocation mode or hold the sender back until every answer
// that is owed has arrived. A clocked driver presents the requests one beat at a time. On
// each accepted request beat it runs its own model of the block table, which yields the
// answer beats that the block must produce. A clocked monitor takes the answer beats and
// compares each of them, field by field, with the oldest answer still owed.
module disk_block_allocator_test import dba_pkg::*; ();

	localparam int           DISK_BLOCKS   = NUM_BLOCKS_DEF;
	localparam logic [6:0]   NO_LINK       = 7'(DISK_BLOCKS);
	localparam int           CYCLE_LIMIT   = 5_000_000;
	localparam int           SETTLE_CYCLES = 300;
	localparam int           PHASE_ITEMS   = 36;

	// What the driver does with one entry of its job queue.
	typedef enum logic [1:0] {
		JOB_REQUEST,
		JOB_SET_MODE,
		JOB_SETTLE
	} job_kind_t;

	typedef struct packed {
		job_kind_t         kind;
		logic              op;
		logic [ID_W-1:0]   id;
		logic [LEN_W-1:0]  len;
		logic [MODE_W-1:0] mode;
		logic              steady;
	} job_t;

	typedef struct packed {
		status_t    st;
		logic [5:0] blk;
		logic [6:0] lnk;
		logic       fin;
	} answer_t;

	logic              clk         = 1'b0;
	logic              arst_n      = 1'b0;
	logic              cfg_wr_en   = 1'b0;
	logic [MODE_W-1:0] cfg_wr_data = '0;
	logic              in_valid    = 1'b0;
	logic              in_ready;
	logic              op          = OP_CREATE;
	logic [ID_W-1:0]   file_id     = '0;
	logic [LEN_W-1:0]  file_length = '0;
	logic              out_valid;
	logic              out_ready   = 1'b0;
	logic [2:0]        status;
	logic [5:0]        block_number;
	logic [6:0]        link_block;
	logic              last;

	job_t              jobs[$];
	answer_t           answers_due[$];

	// The bench's own picture of the disk: which file owns each block, and the mode in force.
	logic [ID_W-1:0]   owner_map [DISK_BLOCKS];
	logic [MODE_W-1:0] mode_now = MODE_CONTIG;

	int                mismatches = 0;
	int                cycles     = 0;
	int                gap_left   = 0;
	int                stall_left = 0;
	logic              no_idle    = 1'b0;
	logic              feed_done  = 1'b0;

	disk_block_allocator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.op           (op),
		.file_id      (file_id),
		.file_length  (file_length),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.block_number (block_number),
		.link_block   (link_block),
		.last         (last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// The run is cut short here if the block stops answering.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	function automatic void push_answer(input status_t st, input int blk, input int lnk,
			input logic fin);
		answer_t a;
		a.st  = st;
		a.blk = 6'(blk);
		a.lnk = 7'(lnk);
		a.fin = fin;
		answers_due.insert(answers_due.size(), a);
	endfunction

	// Applies one accepted request to the disk picture and queues the answer beats it owes.
	function automatic void apply_request(input logic op_i, input logic [ID_W-1:0] id_i,
			input logic [LEN_W-1:0] len_i);
		int   picks[$];
		int   run;
		int   i;
		int   lnk;
		logic present;
		present = 1'b0;
		for (i = 0; i < DISK_BLOCKS; i++)
			if (owner_map[i] == id_i)
				present = 1'b1;

		// A delete frees every block of the file. Id zero never names a file, even though
		// it matches every free block.
		if (op_i == OP_DELETE) begin
			if (id_i == '0 || !present) begin
				push_answer(ST_NOT_FOUND, 0, NO_LINK, 1'b1);
			end else begin
				for (i = 0; i < DISK_BLOCKS; i++)
					if (owner_map[i] == id_i)
						owner_map[i] = '0;
				push_answer(ST_OK, 0, NO_LINK, 1'b1);
			end
			return;
		end

		// On a create the id is checked first, then the zero length, then the space.
		if (id_i == '0 || present) begin
			push_answer(ST_EXISTS, 0, NO_LINK, 1'b1);
			return;
		end
		if (len_i == '0) begin
			push_answer(ST_ZERO_LEN, 0, NO_LINK, 1'b1);
			return;
		end
		if (len_i > MAX_LEN) begin
			push_answer(ST_NO_SPACE, 0, NO_LINK, 1'b1);
			return;
		end

		if (mode_now == MODE_CONTIG) begin
			// First fit: the lowest run of free blocks that is long enough.
			run = 0;
			for (i = 0; i < DISK_BLOCKS; i++) begin
				run = (owner_map[i] == '0) ? run + 1 : 0;
				if (run == int'(len_i) && picks.size() == 0)
					for (int k = 0; k < int'(len_i); k++)
						picks.insert(picks.size(), i + 1 - int'(len_i) + k);
			end
		end else begin
			// Linked and indexed allocation take free blocks in address order.
			for (i = 0; i < DISK_BLOCKS; i++)
				if (owner_map[i] == '0 && picks.size() < int'(len_i))
					picks.insert(picks.size(), i);
		end

		if (picks.size() < int'(len_i)) begin
			push_answer(ST_NO_SPACE, 0, NO_LINK, 1'b1);
			return;
		end

		// Indexed mode points every block at the first one; mode value 3 counts as indexed.
		for (i = 0; i < picks.size(); i++) begin
			if (mode_now == MODE_CONTIG || mode_now == MODE_LINKED)
				lnk = (i + 1 < picks.size()) ? picks[i + 1] : int'(NO_LINK);
			else
				lnk = picks[0];
			owner_map[picks[i]] = id_i;
			push_answer(ST_OK, picks[i], lnk, 1'(i + 1 == picks.size()));
		end
	endfunction

	// Sender. A request beat is held until taken; after it, a random idle gap is drawn unless the
	// request belongs to a stretch without idling. Mode changes and the settle job only go ahead
	// once no answer is owed, so the block is idle when the mode changes.
	always @(posedge clk) begin : drive
		job_t job;
		logic raise;
		logic pulse;
		raise = 1'b0;
		pulse = 1'b0;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				apply_request(op, file_id, file_length);
				gap_left = no_idle ? 0 : $urandom_range(0, 11);
			end
			if (in_valid && !in_ready) begin
				raise = 1'b1;
			end else if (gap_left > 0) begin
				gap_left--;
			end else if (jobs.size() > 0) begin
				job = jobs[0];
				case (job.kind)
					JOB_REQUEST: begin
						op          <= job.op;
						file_id     <= job.id;
						file_length <= job.len;
						no_idle     <= job.steady;
						raise = 1'b1;
						void'(jobs.pop_front());
					end
					JOB_SET_MODE: begin
						if (answers_due.size() == 0) begin
							cfg_wr_data <= job.mode;
							mode_now = job.mode;
							pulse = 1'b1;
							void'(jobs.pop_front());
						end
					end
					default: begin
						if (answers_due.size() == 0)
							void'(jobs.pop_front());
					end
				endcase
			end else begin
				feed_done <= 1'b1;
			end
		end
		in_valid  <= raise;
		cfg_wr_en <= pulse;
	end

	function automatic void check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// Receiver. Each answer beat is checked against the oldest answer owed, and outside a stretch
	// without idling a random stall is then drawn before the next beat is taken.
	always @(posedge clk) begin : watch
		answer_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (answers_due.size() == 0) begin
					$display("%0t: unexpected beat status %0d block %0d link %0d last %0d",
						$time, status, block_number, link_block, last);
					mismatches++;
				end else begin
					want = answers_due.pop_front();
					check_field("status", 8'(want.st), 8'(status));
					check_field("block_number", 8'(want.blk), 8'(block_number));
					check_field("link_block", 8'(want.lnk), 8'(link_block));
					check_field("last", 8'(want.fin), 8'(last));
				end
				stall_left = no_idle ? 0 : $urandom_range(0, 11);
			end else if (stall_left > 0) begin
				stall_left--;
			end
			out_ready <= (stall_left == 0);
		end
	end

	task automatic queue_request(input logic op_i, input int id_i, input int len_i,
			input logic steady);
		job_t j;
		j        = '0;
		j.kind   = JOB_REQUEST;
		j.op     = op_i;
		j.id     = 8'(id_i);
		j.len    = 7'(len_i);
		j.steady = steady;
		jobs.insert(jobs.size(), j);
	endtask

	task automatic queue_job(input job_kind_t kind, input logic [MODE_W-1:0] mode);
		job_t j;
		j      = '0;
		j.kind = kind;
		j.mode = mode;
		jobs.insert(jobs.size(), j);
	endtask

	initial begin : stimulus
		logic [MODE_W-1:0] phase_mode [8];
		int                pick;
		int                id_r;
		int                len_r;
		logic              op_r;
		logic              steady;
		phase_mode = '{MODE_SPARE, MODE_LINKED, MODE_CONTIG, MODE_INDEXED,
			MODE_SPARE, MODE_CONTIG, MODE_LINKED, MODE_INDEXED};
		for (int i = 0; i < DISK_BLOCKS; i++)
			owner_map[i] = '0;

		// Directed opening in first-fit mode: every error code, then a full disk.
		queue_job(JOB_SET_MODE, MODE_CONTIG);
		queue_request(OP_CREATE, 0, 5, 1'b0);
		queue_request(OP_CREATE, 1, 0, 1'b0);
		queue_request(OP_CREATE, 2, 65, 1'b0);
		queue_request(OP_CREATE, 3, 127, 1'b0);
		queue_request(OP_DELETE, 0, 0, 1'b0);
		queue_request(OP_DELETE, 9, 0, 1'b0);
		queue_request(OP_CREATE, 1, 64, 1'b0);
		queue_request(OP_CREATE, 2, 1, 1'b0);
		// The id check comes before the zero length check.
		queue_request(OP_CREATE, 1, 0, 1'b0);
		queue_request(OP_DELETE, 1, 127, 1'b0);
		// Leave a four-block hole; a five-block file must skip it and a four-block one fill it.
		queue_request(OP_CREATE, 255, 3, 1'b0);
		queue_request(OP_CREATE, 4, 4, 1'b0);
		queue_request(OP_CREATE, 5, 2, 1'b0);
		queue_request(OP_DELETE, 4, 0, 1'b0);
		queue_request(OP_CREATE, 6, 5, 1'b0);
		queue_request(OP_CREATE, 7, 4, 1'b0);
		// Linked and indexed files scattered over the holes.
		queue_job(JOB_SET_MODE, MODE_LINKED);
		queue_request(OP_DELETE, 255, 0, 1'b0);
		queue_request(OP_CREATE, 8, 5, 1'b0);
		queue_job(JOB_SET_MODE, MODE_INDEXED);
		queue_request(OP_DELETE, 6, 0, 1'b0);
		queue_request(OP_CREATE, 9, 6, 1'b0);
		queue_request(OP_CREATE, 10, 60, 1'b0);

		// Random phases, one mode each. A small pool of ids keeps files colliding, being
		// deleted and recreated, so the disk fills, fragments and empties again.
		for (int p = 0; p < 8; p++) begin
			queue_job(JOB_SET_MODE, phase_mode[p]);
			steady = (p == 2 || p == 5);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (p == 3 && n == 20)
					queue_job(JOB_SETTLE, MODE_CONTIG);
				op_r = ($urandom_range(0, 99) < 35) ? OP_DELETE : OP_CREATE;
				id_r = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 12)
					: $urandom_range(0, 255);
				pick = $urandom_range(0, 99);
				if (op_r == OP_DELETE)
					len_r = $urandom_range(0, 127);
				else if (pick < 3)
					len_r = 0;
				else if (pick < 80)
					len_r = $urandom_range(1, 8);
				else if (pick < 94)
					len_r = $urandom_range(9, 40);
				else if (pick < 97)
					len_r = $urandom_range(41, 64);
				else
					len_r = $urandom_range(65, 127);
				queue_request(op_r, id_r, len_r, steady);
			end
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (!feed_done || answers_due.size() != 0)
			@(posedge clk);
		// Any stray beat in this window is caught by the monitor.
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

`default_nettype wire
